FILE: rtl/twe_pkg.sv
// ----------------------------------------------------------------------------
// twe_pkg
// Shared codes, widths and controller/datapath interface types for the
// timing wheel expiry core.
// ----------------------------------------------------------------------------
package twe_pkg;

	localparam int OP_W   = 2;
	localparam int ID_W   = 6;
	localparam int KIND_W = 2;

	localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

	typedef struct packed {
		logic ack;
		logic add;
		logic del;
		logic scan_start;
		logic step;
		logic take;
		logic emit_pend;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic pend;
		logic idx_done;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/timing_wheel_expiry_core.sv
// ----------------------------------------------------------------------------
// timing_wheel_expiry_core
// Hashed timing wheel: files node ids one slot behind the pointer and expires
// a slot's nodes on each tick.
// ----------------------------------------------------------------------------
// Add and delete requests each return one acknowledge on the next cycle. A
// tick request scans the node slot memory one entry per cycle while no
// expiry is held up by out_ready low; expiries come out in ascending node id
// order, last set on the final one, or a single none result if the slot was
// empty.
// No new request is taken while a tick scan is in progress.
module timing_wheel_expiry_core
	import twe_pkg::*;
#(
	parameter int SLOT_COUNT = 16,
	parameter int NODE_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [ID_W-1:0]   node_id,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] kind,
	output logic [ID_W-1:0]   node_id_res,
	output logic              last
);

	cmd_t cmd;
	sts_t sts;

	twe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	twe_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.NODE_COUNT (NODE_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.node_id     (node_id),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.kind        (kind),
		.node_id_res (node_id_res),
		.last        (last)
	);

endmodule

FILE: rtl/twe_ctrl.sv
// ----------------------------------------------------------------------------
// twe_ctrl
// Request sequencing: add/delete acknowledge, tick scan with one-deep
// lookahead so the final expiry can be flagged, and the closing result.
// ----------------------------------------------------------------------------
module twe_ctrl
	import twe_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] op,
	output logic            in_ready,
	input  sts_t            sts,
	output cmd_t            cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       stall;

	assign stall = sts.match && sts.pend && !sts.out_free;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					case (op)
						OP_ADD: begin
							cmd.ack = 1'b1;
							cmd.add = 1'b1;
						end
						OP_DEL: begin
							cmd.ack = 1'b1;
							cmd.del = 1'b1;
						end
						OP_TICK: begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					cmd.step      = 1'b1;
					cmd.take      = sts.match;
					cmd.emit_pend = sts.match && sts.pend;
					if (sts.idx_done)
						state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: rtl/twe_dp.sv
// ----------------------------------------------------------------------------
// twe_dp
// Node marks, node slot memory, slot pointer, scan counter with registered
// read stage, pending expiry holder and the output register.
// ----------------------------------------------------------------------------
module twe_dp
	import twe_pkg::*;
#(
	parameter int SLOT_COUNT = 16,
	parameter int NODE_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ID_W-1:0]   node_id,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [KIND_W-1:0] kind,
	output logic [ID_W-1:0]   node_id_res,
	output logic              last
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW = $clog2(NODE_COUNT + 1);
	localparam int IW = ID_W + 1;

	logic [SW-1:0]         slot_mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] active_q;
	logic [SW-1:0]         cur_q;
	logic [SW-1:0]         prev_slot;
	logic [CW-1:0]         idx_q;
	logic                  idx_done;
	logic                  s1_vld_s1;
	logic [AW-1:0]         s1_idx_s1;
	logic [SW-1:0]         rd_slot_s1;
	logic                  pend_q;
	logic [AW-1:0]         pend_id_q;
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [ID_W-1:0]       id_q;
	logic                  last_q;
	logic                  id_ok;
	logic [AW-1:0]         wr_addr;

	assign id_ok     = IW'(node_id) < IW'(NODE_COUNT);
	assign wr_addr   = node_id[AW-1:0];
	assign prev_slot = (cur_q == '0) ? SW'(SLOT_COUNT - 1) : cur_q - 1'b1;
	assign idx_done  = idx_q == CW'(NODE_COUNT);

	assign sts.match    = s1_vld_s1 && active_q[s1_idx_s1] && (rd_slot_s1 == cur_q);
	assign sts.pend     = pend_q;
	assign sts.idx_done = idx_done;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.add && id_ok)
			slot_mem[wr_addr] <= prev_slot;
		if (cmd.step)
			rd_slot_s1 <= slot_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			cur_q     <= '0;
			idx_q     <= '0;
			s1_vld_s1 <= 1'b0;
			s1_idx_s1 <= '0;
			pend_q    <= 1'b0;
			pend_id_q <= '0;
		end else begin
			if (cmd.add && id_ok)
				active_q[wr_addr] <= 1'b1;
			if (cmd.del && id_ok)
				active_q[wr_addr] <= 1'b0;
			if (cmd.take)
				active_q[s1_idx_s1] <= 1'b0;

			if (cmd.scan_start) begin
				idx_q     <= '0;
				s1_vld_s1 <= 1'b0;
				pend_q    <= 1'b0;
			end else if (cmd.step) begin
				s1_vld_s1 <= !idx_done;
				s1_idx_s1 <= idx_q[AW-1:0];
				if (!idx_done)
					idx_q <= idx_q + 1'b1;
			end

			if (cmd.take) begin
				pend_q    <= 1'b1;
				pend_id_q <= s1_idx_s1;
			end else if (cmd.emit_final) begin
				pend_q <= 1'b0;
			end

			if (cmd.emit_final)
				cur_q <= (cur_q == SW'(SLOT_COUNT - 1)) ? '0 : cur_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.ack || cmd.emit_pend || cmd.emit_final)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ack) begin
			kind_q <= KIND_ACK;
			id_q   <= node_id;
			last_q <= 1'b1;
		end else if (cmd.emit_pend) begin
			kind_q <= KIND_EXPIRED;
			id_q   <= ID_W'(pend_id_q);
			last_q <= 1'b0;
		end else if (cmd.emit_final) begin
			kind_q <= pend_q ? KIND_EXPIRED : KIND_NONE;
			id_q   <= pend_q ? ID_W'(pend_id_q) : '0;
			last_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign node_id_res = id_q;
	assign last        = last_q;

endmodule

FILE: rtl/twe_checker.sv
// ----------------------------------------------------------------------------
// twe_checker
// Port-level checks on the timing wheel expiry core, bound to the top level.
// ----------------------------------------------------------------------------
module twe_checker
	import twe_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OP_W-1:0]   op,
	input logic [ID_W-1:0]   node_id,
	input logic              out_valid,
	input logic              out_ready,
	input logic [KIND_W-1:0] kind,
	input logic [ID_W-1:0]   node_id_res,
	input logic              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_ack_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_ADD || op == OP_DEL) |=>
		out_valid && kind == KIND_ACK && last && node_id_res == $past(node_id))
		else $error("acknowledge missing or wrong");

	a_none_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NONE |-> last && node_id_res == '0)
		else $error("malformed none result");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_TICK |=> !in_ready)
		else $error("request taken during tick scan");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_ACK || kind == KIND_EXPIRED || kind == KIND_NONE)
		else $error("illegal result kind");

endmodule

bind timing_wheel_expiry_core twe_checker u_twe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.op          (op),
	.node_id     (node_id),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.node_id_res (node_id_res),
	.last        (last)
);
